/* src/kvt_pkg.sv */
// Shared codes and field widths for the compacting key/value table.
package kvt_pkg;

  localparam int ACTION_WIDTH = 2;
  localparam int STATUS_WIDTH = 2;
  localparam int CFG_WIDTH    = 5;
  localparam int HELD_WIDTH   = 5;

  localparam logic [ACTION_WIDTH-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_WIDTH-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_WIDTH-1:0] ACT_GET    = 2'd2;

  localparam logic [STATUS_WIDTH-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL      = 2'd2;

endpackage

/* src/kvt_mem.sv */
// Simple dual-port slot memory with one write port and a registered read port.
module kvt_mem #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/compacting_key_value_table.sv */
// Top level of the compacting key/value table: request sequencer around the slot memory.
//
//   channel  direction  handshake            payload
//   in       in         in_valid/in_stall    action, key_first, key_second, value_in
//   out      out        out_valid/out_stall  status, value_out, entries_held
//   cfg      in         cfg_write            cfg_data (capacity_limit)
//
// An item passes an accept step, a scan through the slot memory read port (ended early
// on a hit), compaction of the later slots on a remove, and a hand-off of the result;
// the scan and the compaction read one slot per cycle.
// Reset clears the entry count, the limit (to DEPTH) and all handshake state; slots need no clear.
// A stalled result waits in the output register while the next item is accepted.
module compacting_key_value_table #(
  parameter int DEPTH          = 16,
  parameter int KEY_PART_WIDTH = 32,
  parameter int VALUE_WIDTH    = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [kvt_pkg::ACTION_WIDTH-1:0]  action,
  input  logic [KEY_PART_WIDTH-1:0]         key_first,
  input  logic [KEY_PART_WIDTH-1:0]         key_second,
  input  logic [VALUE_WIDTH-1:0]            value_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [kvt_pkg::STATUS_WIDTH-1:0]  status,
  output logic [VALUE_WIDTH-1:0]            value_out,
  output logic [kvt_pkg::HELD_WIDTH-1:0]    entries_held,
  input  logic                              cfg_write,
  input  logic [kvt_pkg::CFG_WIDTH-1:0]     cfg_data
);

  import kvt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;
  localparam int EW = 2 * KEY_PART_WIDTH + VALUE_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                    state, state_next;
  logic [ACTION_WIDTH-1:0]   req_action, req_action_next;
  logic [KEY_PART_WIDTH-1:0] req_k1, req_k1_next;
  logic [KEY_PART_WIDTH-1:0] req_k2, req_k2_next;
  logic [VALUE_WIDTH-1:0]    req_v, req_v_next;
  logic [CW-1:0]             count, count_next;
  logic [LW-1:0]             cap_limit, cap_limit_next;
  logic [CW-1:0]             scan_idx, scan_idx_next;
  logic                      pend, pend_next;
  logic [AW-1:0]             pend_idx, pend_idx_next;
  logic [STATUS_WIDTH-1:0]   res_status, res_status_next;
  logic [VALUE_WIDTH-1:0]    res_value, res_value_next;
  logic                      out_valid_next;
  logic [STATUS_WIDTH-1:0]   status_next;
  logic [VALUE_WIDTH-1:0]    value_out_next;
  logic [HELD_WIDTH-1:0]     entries_held_next;

  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  logic [EW-1:0]             mem_wdata, mem_rdata;

  logic [KEY_PART_WIDTH-1:0] rd_k1, rd_k2;
  logic [VALUE_WIDTH-1:0]    rd_v;
  logic [LW-1:0]             eff_limit;
  logic                      hit, more;

  kvt_mem #(
    .WIDTH (EW),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_k1 = mem_rdata[EW-1 -: KEY_PART_WIDTH];
  assign rd_k2 = mem_rdata[VALUE_WIDTH +: KEY_PART_WIDTH];
  assign rd_v  = mem_rdata[VALUE_WIDTH-1:0];

  assign eff_limit = (cap_limit == '0) ? LW'(1) :
                     (cap_limit > LW'(DEPTH)) ? LW'(DEPTH) : cap_limit;

  assign hit      = pend && (rd_k1 == req_k1) && (rd_k2 == req_k2);
  assign more     = scan_idx < count;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next        = state;
    req_action_next   = req_action;
    req_k1_next       = req_k1;
    req_k2_next       = req_k2;
    req_v_next        = req_v;
    count_next        = count;
    cap_limit_next    = cap_limit;
    scan_idx_next     = scan_idx;
    pend_next         = pend;
    pend_idx_next     = pend_idx;
    res_status_next   = res_status;
    res_value_next    = res_value;
    out_valid_next    = out_valid && out_stall;
    status_next       = status;
    value_out_next    = value_out;
    entries_held_next = entries_held;
    mem_we            = 1'b0;
    mem_waddr         = pend_idx;
    mem_wdata         = {req_k1, req_k2, req_v};
    mem_re            = 1'b0;
    mem_raddr         = scan_idx[AW-1:0];

    if (cfg_write) begin
      cap_limit_next = LW'(cfg_data);
    end

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_action_next = action;
          req_k1_next     = key_first;
          req_k2_next     = key_second;
          req_v_next      = value_in;
          scan_idx_next   = '0;
          pend_next       = 1'b0;
          state_next      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          pend_next       = 1'b0;
          res_status_next = ST_OK;
          res_value_next  = '0;
          state_next      = S_DONE;
          case (req_action)
            ACT_ADD: begin
              mem_we    = 1'b1;
              mem_waddr = pend_idx;
            end
            ACT_GET: begin
              res_value_next = rd_v;
            end
            ACT_REMOVE: begin
              res_value_next = rd_v;
              scan_idx_next  = CW'(pend_idx) + CW'(1);
              state_next     = S_SHIFT;
            end
            default: begin
              res_status_next = ST_NOT_FOUND;
            end
          endcase
        end else if (more) begin
          mem_re        = 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = scan_idx[AW-1:0];
          scan_idx_next = scan_idx + CW'(1);
        end else begin
          pend_next       = 1'b0;
          res_value_next  = '0;
          res_status_next = ST_NOT_FOUND;
          state_next      = S_DONE;
          if (req_action == ACT_ADD) begin
            if (LW'(count) >= eff_limit) begin
              res_status_next = ST_FULL;
            end else begin
              mem_we          = 1'b1;
              mem_waddr       = count[AW-1:0];
              count_next      = count + CW'(1);
              res_status_next = ST_OK;
            end
          end
        end
      end
      S_SHIFT: begin
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_idx - AW'(1);
          mem_wdata = mem_rdata;
        end
        if (more) begin
          mem_re        = 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = scan_idx[AW-1:0];
          scan_idx_next = scan_idx + CW'(1);
        end else begin
          pend_next  = 1'b0;
          count_next = count - CW'(1);
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next    = 1'b1;
          status_next       = res_status;
          value_out_next    = res_value;
          entries_held_next = HELD_WIDTH'(count);
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cap_limit <= LW'(DEPTH);
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cap_limit <= cap_limit_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req_action   <= req_action_next;
    req_k1       <= req_k1_next;
    req_k2       <= req_k2_next;
    req_v        <= req_v_next;
    scan_idx     <= scan_idx_next;
    pend_idx     <= pend_idx_next;
    res_status   <= res_status_next;
    res_value    <= res_value_next;
    status       <= status_next;
    value_out    <= value_out_next;
    entries_held <= entries_held_next;
  end

endmodule

/* src/kvt_checker.sv */
// Port-level assertions for the compacting key/value table and their bind.
module kvt_checker #(
  parameter int DEPTH          = 16,
  parameter int VALUE_WIDTH    = 32
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [kvt_pkg::STATUS_WIDTH-1:0]  status,
  input logic [VALUE_WIDTH-1:0]            value_out,
  input logic [kvt_pkg::HELD_WIDTH-1:0]    entries_held
);

  import kvt_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while a request is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(value_out)
      && $stable(entries_held))
    else $error("stalled result beat changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || status == ST_NOT_FOUND) |-> value_out == '0)
    else $error("failed request returned a value");

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(entries_held) <= DEPTH)
    else $error("entry count above table depth");

endmodule

bind compacting_key_value_table kvt_checker #(
  .DEPTH          (DEPTH),
  .VALUE_WIDTH    (VALUE_WIDTH)
) u_kvt_checker (.*);

/* verif/kvt_result_checker.sv */
// Checker for the compacting key/value table: tracks the table contents and compares every result beat.
`timescale 1ns / 1ps

module kvt_result_checker #(
  parameter int DEPTH          = 16,
  parameter int KEY_PART_WIDTH = 32,
  parameter int VALUE_WIDTH    = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [kvt_pkg::ACTION_WIDTH-1:0]   action,
  input  logic [KEY_PART_WIDTH-1:0]          key_first,
  input  logic [KEY_PART_WIDTH-1:0]          key_second,
  input  logic [VALUE_WIDTH-1:0]             value_in,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [kvt_pkg::STATUS_WIDTH-1:0]   status,
  input  logic [VALUE_WIDTH-1:0]             value_out,
  input  logic [kvt_pkg::HELD_WIDTH-1:0]     entries_held,
  input  logic                               cfg_write,
  input  logic [kvt_pkg::CFG_WIDTH-1:0]      cfg_data,
  output int                                 fault_count,
  output int                                 awaiting
);

  import kvt_pkg::*;

  typedef struct packed {
    logic [STATUS_WIDTH-1:0] status;
    logic [VALUE_WIDTH-1:0]  value;
    logic [HELD_WIDTH-1:0]   held;
  } reply_t;

  // Entries are kept packed from index 0, as the block keeps them.
  logic [KEY_PART_WIDTH-1:0] kept_first  [DEPTH];
  logic [KEY_PART_WIDTH-1:0] kept_second [DEPTH];
  logic [VALUE_WIDTH-1:0]    kept_value  [DEPTH];
  int                        kept_count = 0;
  logic [CFG_WIDTH-1:0]      limit_setting = CFG_WIDTH'(DEPTH);
  reply_t                    replies_due [$];
  int                        faults = 0;

  function automatic reply_t serve_request(input logic [ACTION_WIDTH-1:0]   act,
                                           input logic [KEY_PART_WIDTH-1:0] k1,
                                           input logic [KEY_PART_WIDTH-1:0] k2,
                                           input logic [VALUE_WIDTH-1:0]    v);
    reply_t r;
    int     hit;
    int     lim;
    int     i;
    r.status = ST_NOT_FOUND;
    r.value  = '0;
    hit      = -1;
    for (i = 0; i < kept_count; i++) begin
      if (hit < 0 && kept_first[i] == k1 && kept_second[i] == k2) hit = i;
    end
    if (int'(limit_setting) == 0) lim = 1;
    else if (int'(limit_setting) > DEPTH) lim = DEPTH;
    else lim = int'(limit_setting);
    case (act)
      ACT_ADD: begin
        if (hit >= 0) begin
          kept_value[hit] = v;
          r.status = ST_OK;
        end else if (kept_count >= lim) begin
          r.status = ST_FULL;
        end else begin
          kept_first[kept_count]  = k1;
          kept_second[kept_count] = k2;
          kept_value[kept_count]  = v;
          kept_count++;
          r.status = ST_OK;
        end
      end
      ACT_REMOVE: begin
        if (hit >= 0) begin
          r.value = kept_value[hit];
          for (i = hit; i < kept_count - 1; i++) begin
            kept_first[i]  = kept_first[i+1];
            kept_second[i] = kept_second[i+1];
            kept_value[i]  = kept_value[i+1];
          end
          kept_count--;
          r.status = ST_OK;
        end
      end
      ACT_GET: begin
        if (hit >= 0) begin
          r.value  = kept_value[hit];
          r.status = ST_OK;
        end
      end
      default: begin
      end
    endcase
    r.held = HELD_WIDTH'(kept_count);
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      kept_count    = 0;
      limit_setting = CFG_WIDTH'(DEPTH);
      replies_due.delete();
    end else begin
      if (cfg_write) limit_setting = cfg_data;
      // Result first: a beat leaving now belongs to an earlier request.
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("%0t: result beat with none due: status %0d value %h held %0d",
                     $realtime, status, value_out, entries_held);
        end else begin
          want = replies_due.pop_front();
          if (want != {status, value_out, entries_held}) begin
            faults++;
            if (faults <= 10)
              $display("%0t: mismatch: expected status %0d value %h held %0d, got %0d %h %0d",
                       $realtime, want.status, want.value, want.held,
                       status, value_out, entries_held);
          end
        end
      end
      if (in_valid && !in_stall)
        replies_due.push_back(serve_request(action, key_first, key_second, value_in));
    end
    fault_count <= faults;
    awaiting    <= replies_due.size();
  end

endmodule

/* verif/compacting_key_value_table_tb.sv */
// Testbench top for the compacting key/value table: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module compacting_key_value_table_tb;
  import kvt_pkg::*;

  localparam int DEPTH          = 16;
  localparam int KEY_PART_WIDTH = 32;
  localparam int VALUE_WIDTH    = 32;
  localparam int POOL_SIZE      = 24;
  localparam int PHASE_ITEMS    = 115;
  localparam int LONG_HOLD      = 400;

  typedef logic [KEY_PART_WIDTH-1:0] key_t;
  typedef logic [VALUE_WIDTH-1:0]    val_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [ACTION_WIDTH-1:0] action;
  key_t                    key_first;
  key_t                    key_second;
  val_t                    value_in;
  logic                    out_valid;
  logic                    out_stall;
  logic [STATUS_WIDTH-1:0] status;
  val_t                    value_out;
  logic [HELD_WIDTH-1:0]   entries_held;
  logic                    cfg_write;
  logic [CFG_WIDTH-1:0]    cfg_data;
  int                      fault_count;
  int                      awaiting;

  key_t pool_first  [POOL_SIZE];
  key_t pool_second [POOL_SIZE];
  int   hold_ask   = 0;
  int   holds_done = 0;

  localparam key_t ONES = '1;
  localparam key_t ZERO = '0;
  localparam logic [CFG_WIDTH-1:0] LIMIT_STEPS [8] = '{
    5'd16, 5'd3, 5'd31, 5'd8, 5'd17, 5'd1, 5'd0, 5'd16
  };

  compacting_key_value_table #(
    .DEPTH(DEPTH), .KEY_PART_WIDTH(KEY_PART_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)
  ) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .key_first(key_first), .key_second(key_second), .value_in(value_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .value_out(value_out), .entries_held(entries_held),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  kvt_result_checker #(
    .DEPTH(DEPTH), .KEY_PART_WIDTH(KEY_PART_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)
  ) i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .key_first(key_first), .key_second(key_second), .value_in(value_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .value_out(value_out), .entries_held(entries_held),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .fault_count(fault_count), .awaiting(awaiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // Hold the beat until accepted; returns at the accepting edge.
  task automatic offer(input logic [ACTION_WIDTH-1:0] act, input key_t k1, input key_t k2,
                       input val_t v);
    in_valid   <= 1'b1;
    action     <= act;
    key_first  <= k1;
    key_second <= k2;
    value_in   <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  task automatic set_limit(input logic [CFG_WIDTH-1:0] lim);
    cfg_write <= 1'b1;
    cfg_data  <= lim;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_request();
    int   r;
    int   p;
    logic [ACTION_WIDTH-1:0] act;
    key_t k1;
    key_t k2;
    r = $urandom_range(0, 99);
    if (r < 45) act = ACT_ADD;
    else if (r < 70) act = ACT_REMOVE;
    else if (r < 94) act = ACT_GET;
    else act = ~ACT_ADD;
    p = $urandom_range(0, POOL_SIZE - 1);
    k1 = pool_first[p];
    k2 = pool_second[p];
    if ($urandom_range(0, 9) == 0) begin
      k1 = $urandom;
      k2 = $urandom;
    end
    offer(act, k1, k2, $urandom);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever the sender asks for one.
  initial begin
    int n;
    out_stall = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (holds_done < hold_ask) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else begin
        n = pause_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        if ($urandom_range(0, 9) == 0) n = $urandom_range(20, 60);
        else n = $urandom_range(1, 6);
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    int g;
    bit burst;
    rst        = 1'b1;
    in_valid   = 1'b0;
    action     = ACT_ADD;
    key_first  = '0;
    key_second = '0;
    value_in   = '0;
    cfg_write  = 1'b0;
    cfg_data   = '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_first[i]  = $urandom;
      pool_second[i] = $urandom;
      if (i % 4 == 1) pool_first[i] = pool_first[i-1];
      if (i % 4 == 3) pool_second[i] = pool_second[i-2];
    end
    pool_first[0]  = ONES;
    pool_second[0] = ZERO;
    pool_first[2]  = ZERO;
    pool_second[2] = ONES;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, unused action, two-part matching, update, remove with compaction.
    set_limit(5'd31);
    offer(ACT_GET, ONES, ZERO, '0);
    offer(ACT_REMOVE, ONES, ZERO, '0);
    offer(~ACT_ADD, ONES, ONES, '1);
    offer(ACT_ADD, ONES, ZERO, '1);
    offer(ACT_ADD, ZERO, ONES, '0);
    offer(ACT_ADD, ONES, 32'h0000_0001, 32'h1234_5678);
    offer(ACT_GET, ONES, ONES, '0);
    offer(ACT_GET, ONES, 32'h0000_0001, '0);
    offer(ACT_ADD, ONES, ZERO, 32'h5A5A_5A5A);
    offer(ACT_GET, ONES, ZERO, '0);
    offer(ACT_REMOVE, ONES, ZERO, '1);
    offer(ACT_GET, ZERO, ONES, '0);
    offer(ACT_GET, ONES, 32'h0000_0001, '0);
    offer(ACT_REMOVE, ONES, ZERO, '0);
    in_valid <= 1'b0;
    drain();

    // Limit of zero, below the current count.
    set_limit(5'd0);
    offer(ACT_ADD, ZERO, ZERO, 32'h0000_0001);
    offer(ACT_ADD, ZERO, ONES, 32'hA5A5_A5A5);
    offer(ACT_GET, ONES, 32'h0000_0001, '0);
    offer(ACT_REMOVE, ZERO, ONES, '0);
    offer(ACT_ADD, ZERO, ZERO, 32'h0000_0001);
    offer(ACT_REMOVE, ONES, 32'h0000_0001, '0);
    offer(ACT_ADD, ZERO, ZERO, 32'h0000_0001);
    offer(ACT_ADD, 32'h0000_0001, 32'h0000_0001, 32'h0000_0002);
    offer(~ACT_ADD, ZERO, ZERO, '1);
    in_valid <= 1'b0;
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_limit(LIMIT_STEPS[ph]);
      burst = (ph == 1 || ph == 2 || ph == 5 || $urandom_range(0, 3) == 0);
      if (ph == 2 || ph == 5) hold_ask++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_request();
        g = burst ? 0 : pause_len();
        if (g > 0) begin
          in_valid <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
      in_valid <= 1'b0;
      drain();
    end

    repeat (DEPTH + 8) @(posedge clk);
    if (fault_count == 0 && awaiting == 0) begin
      $display("PASS compacting_key_value_table");
    end else begin
      $display("FAIL compacting_key_value_table");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAIL compacting_key_value_table");
    $finish;
  end

endmodule
